// ===== rtl/ffila_pkg.sv =====
`timescale 1ns / 1ps
package ffila_pkg;

  localparam int unsigned FrameW   = 31;
  localparam int unsigned RawW     = 32;
  localparam int unsigned LaneOutW = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;  // take the input beat, resolve bounds, rewind the scan
    logic rd;    // read the lane end at the scan index
    logic step;  // advance the scan index
    logic take;  // keep the lane at the scan index for this interval
    logic emit;  // commit the decision and load the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic at_end;    // scan index has reached the open lane count
    logic hit;       // read lane end lies strictly before the start
    logic out_free;  // output register can take a result this cycle
  } stat_t;

endpackage

// ===== rtl/ffila_ctrl.sv =====
`timescale 1ns / 1ps
module ffila_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  ffila_pkg::stat_t stat_i,
  output ffila_pkg::cmd_t  cmd_o
);
  import ffila_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RD;
        end
      end
      ST_RD: begin
        // no lane left to try: open a new one or flag overflow
        if (stat_i.at_end) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = ST_CMP;
        end
      end
      ST_CMP: begin
        if (stat_i.hit) begin
          cmd_o.take = 1'b1;
          state_d    = ST_EMIT;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = ST_RD;
        end
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_cmp_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> ($past(state_q) == ST_RD))
    else $error("compare without a preceding read");

  a_end_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD && stat_i.at_end) |=> (state_q == ST_EMIT))
    else $error("scan end did not lead to emit");

  a_emit_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !stat_i.out_free) |=> (state_q == ST_EMIT))
    else $error("result dropped while output busy");

endmodule

// ===== rtl/ffila_dp.sv =====
`timescale 1ns / 1ps
module ffila_dp #(
  parameter int unsigned MAX_LANES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [ffila_pkg::FrameW-1:0] total_frames_i,
  input  logic [ffila_pkg::RawW-1:0]   raw_start_i,
  input  logic [ffila_pkg::RawW-1:0]   raw_end_i,
  input  logic                        end_given_i,
  input  logic                        new_layout_i,
  input  ffila_pkg::cmd_t             cmd_i,
  output ffila_pkg::stat_t            stat_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ffila_pkg::LaneOutW-1:0] out_lane_o,
  output logic [ffila_pkg::FrameW-1:0] out_start_o,
  output logic [ffila_pkg::FrameW-1:0] out_end_o,
  output logic                        out_opened_o,
  output logic                        out_overflow_o
);
  import ffila_pkg::*;

  localparam int unsigned AW = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
  localparam int unsigned CW = $clog2(MAX_LANES + 1);

  logic [FrameW-1:0] lane_end_mem [MAX_LANES];
  logic [FrameW-1:0] rd_data_q;

  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [FrameW-1:0] start_q, end_q;
  logic              hit_q;

  logic [FrameW-1:0] start_res, end_res;
  logic [RawW-1:0]   cand;
  logic              full, wr_en;

  // resolve the interval bounds from the input beat
  always_comb begin
    start_res = raw_start_i[RawW-1] ? '0 : raw_start_i[FrameW-1:0];
    if (end_given_i) begin
      cand = raw_end_i;
    end else if (total_frames_i != '0) begin
      cand = {1'b0, total_frames_i - FrameW'(1)};
    end else begin
      cand = {1'b0, start_res};
    end
    end_res = ($signed(cand) > $signed({1'b0, start_res})) ? cand[FrameW-1:0] : start_res;
  end

  assign full  = (count_q == CW'(MAX_LANES));
  assign wr_en = cmd_i.emit && (hit_q || !full);

  always_comb begin
    count_d = count_q;
    idx_d   = idx_q;
    if (cmd_i.load) begin
      idx_d = '0;
      if (new_layout_i) begin
        count_d = '0;
      end
    end else if (cmd_i.step) begin
      idx_d = idx_q + CW'(1);
    end else if (cmd_i.emit && !hit_q && !full) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      if (cmd_i.emit) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      start_q <= start_res;
      end_q   <= end_res;
      hit_q   <= 1'b0;
    end else if (cmd_i.step) begin
      hit_q <= 1'b0;
    end else if (cmd_i.rd) begin
      hit_q <= 1'b0;
    end else if (cmd_i.take) begin
      hit_q <= 1'b1;
    end
    if (cmd_i.emit) begin
      out_lane_o     <= (hit_q || !full) ? LaneOutW'(idx_q) : '0;
      out_start_o    <= start_q;
      out_end_o      <= end_q;
      out_opened_o   <= !hit_q && !full;
      out_overflow_o <= !hit_q && full;
    end
  end

  // lane end store: one read port, one write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_data_q <= lane_end_mem[idx_q[AW-1:0]];
    end
    if (wr_en) begin
      lane_end_mem[idx_q[AW-1:0]] <= end_q;
    end
  end

  // the hit flag is only used by the controller in the compare state
  logic hit_now;
  assign hit_now = (start_q > rd_data_q);

  always_comb begin
    stat_o.at_end   = (idx_q == count_q);
    stat_o.hit      = hit_now;
    stat_o.out_free = !out_valid_o || out_ready_i;
  end

  // remember a lane end read since the last load or step, checked when emit reuses a lane
  logic hit_seen_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_seen_q <= 1'b0;
    end else if (cmd_i.load) begin
      hit_seen_q <= 1'b0;
    end else if (cmd_i.rd) begin
      hit_seen_q <= 1'b1;
    end else if (cmd_i.step) begin
      hit_seen_q <= 1'b0;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_LANES))
    else $error("open lane count beyond capacity");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= count_q)
    else $error("scan index past open lanes");

  a_ovf_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_overflow_o) |-> (out_lane_o == '0 && !out_opened_o))
    else $error("overflow result carries a lane");

  a_emit_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && hit_q) |-> hit_seen_q)
    else $error("lane reused without a read");

endmodule

// ===== rtl/first_fit_interval_lane_assigner_top.sv =====
`timescale 1ns / 1ps
// Channel         Dir  Beat contents (lowest bit first)
// s_axis          in   tdata: raw_start[31:0], raw_end[63:32]; tuser: end_given, new_layout
// m_axis          out  tdata: lane[3:0], span_start[34:4], span_end[65:35], zeros;
//                      tuser: opened_lane, overflow
// total_frames    in   write enable plus 31-bit value, taken on any rising clock edge with the enable high
//
// Steps: take the beat, then for each open lane tried a store read and a compare, then commit;
// when no open lane fits, a final visit to the read state finds the scan at its end first.
// The registered read of the lane end store is why each lane tried needs both states.
// Reset clears the open lane count and the output valid; the lane store is not cleared.
// A waiting result sits in the output register; the next beat is taken meanwhile and
// only its commit waits for the register to drain.
module first_fit_interval_lane_assigner_top #(
  parameter int unsigned MAX_LANES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        total_frames_we_i,
  input  logic [30:0] total_frames_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // raw_start, raw_end
  input  logic [1:0]  s_axis_tuser,   // end_given, new_layout
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // lane, span_start, span_end, zero fill
  output logic [1:0]  m_axis_tuser    // opened_lane, overflow
);
  import ffila_pkg::*;

  logic [FrameW-1:0]   total_frames_q;
  cmd_t                cmd;
  stat_t               stat;
  logic [LaneOutW-1:0] lane;
  logic [FrameW-1:0]   span_start, span_end;
  logic                opened, overflow;

  // hold the timeline length until the next write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_frames_q <= '0;
    end else if (total_frames_we_i) begin
      total_frames_q <= total_frames_i;
    end
  end

  ffila_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  ffila_dp #(
    .MAX_LANES (MAX_LANES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .total_frames_i (total_frames_q),
    .raw_start_i    (s_axis_tdata[31:0]),
    .raw_end_i      (s_axis_tdata[63:32]),
    .end_given_i    (s_axis_tuser[0]),
    .new_layout_i   (s_axis_tuser[1]),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_lane_o     (lane),
    .out_start_o    (span_start),
    .out_end_o      (span_end),
    .out_opened_o   (opened),
    .out_overflow_o (overflow)
  );

  // pack the result beat
  assign m_axis_tdata = {6'b0, span_end, span_start, lane};
  assign m_axis_tuser = {overflow, opened};

endmodule

// ===== tb/tb_first_fit_interval_lane_assigner_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the first-fit lane assigner: a short directed table, then
// random layouts of start-ordered intervals mixed with raw noise, run under several
// timeline lengths. Each output beat is checked against the table's answer or a local first-fit model.
module tb_first_fit_interval_lane_assigner_top;
  import ffila_pkg::*;

  localparam int unsigned NumLanes    = 16;
  localparam longint      FrameMax    = 64'h7FFF_FFFF;
  localparam int          StallLimit  = 2000;  // cycles with no beat on either side
  localparam int          LongHold    = 300;   // receiver back-pressure stretch
  localparam int          DrainCycles = 40;    // margin for the worst beat: all 16 lanes tried, none fits
  localparam int          NumPhases   = 5;
  localparam int          PhaseItems  = 376;

  // One result beat, fields as carried on m_axis
  typedef struct packed {
    logic [LaneOutW-1:0] lane;
    logic [FrameW-1:0]   span_start;
    logic [FrameW-1:0]   span_end;
    logic                opened;
    logic                overflow;
  } span_res_t;

  // One row of the directed table; typed rows carry their answer with them
  typedef struct {
    logic signed [RawW-1:0] raw_start;
    logic signed [RawW-1:0] raw_end;
    logic                   given;
    logic                   clear;
    logic                   typed;
    span_res_t              want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic total_frames_we_i = 1'b0;
  logic [30:0] total_frames_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // raw_start, raw_end
  logic [1:0] s_axis_tuser = '0;    // end_given, new_layout
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;        // lane, span_start, span_end, zero fill
  logic [1:0] m_axis_tuser;         // opened_lane, overflow

  // Local copy of the block's state and register
  logic [FrameW-1:0] lane_busy_until [NumLanes];
  int unsigned       lanes_open = 0;
  logic [FrameW-1:0] frames_total = '0;

  span_res_t spans_due [$];
  int  mismatches = 0;
  int  stall_cycles = 0;
  int  idle_pct = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  span_res_t got, want;

  first_fit_interval_lane_assigner_top #(
    .MAX_LANES(NumLanes)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .total_frames_we_i(total_frames_we_i),
    .total_frames_i   (total_frames_i),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Resolve the bounds of one interval, pick the first lane that has ended before
  // it starts, else open a lane, else flag overflow; update the lane ends.
  function automatic span_res_t assign_lane(input logic signed [RawW-1:0] raw_start,
                                            input logic signed [RawW-1:0] raw_end,
                                            input logic given, input logic clear);
    span_res_t   r;
    longint      s;
    longint      e;
    longint      cand;
    int unsigned idx;
    bit          hit;
    idx = 0;
    hit = 1'b0;
    r = '0;
    if (clear) lanes_open = 0;
    s = (raw_start < 0) ? 0 : longint'(raw_start);
    if (given) cand = longint'(raw_end);
    else cand = (frames_total != 0) ? longint'(frames_total) - 1 : s;
    e = (cand > s) ? cand : s;
    for (int unsigned i = 0; i < lanes_open; i++) begin
      if (!hit && s > longint'(lane_busy_until[i])) begin
        hit = 1'b1;
        idx = i;
      end
    end
    if (hit) begin
      lane_busy_until[idx] = e[FrameW-1:0];
    end else if (lanes_open < NumLanes) begin
      idx = lanes_open;
      lane_busy_until[idx] = e[FrameW-1:0];
      lanes_open++;
      r.opened = 1'b1;
    end else begin
      idx = 0;
      r.overflow = 1'b1;
    end
    r.lane = idx[LaneOutW-1:0];
    r.span_start = s[FrameW-1:0];
    r.span_end = e[FrameW-1:0];
    return r;
  endfunction

  function automatic plan_row_t mk_row(input logic signed [RawW-1:0] rs,
                                       input logic signed [RawW-1:0] re,
                                       input logic given, input logic clear,
                                       input logic typed, input int unsigned lane,
                                       input logic [FrameW-1:0] ss, input logic [FrameW-1:0] se,
                                       input logic opened, input logic overflow);
    plan_row_t p;
    p.raw_start = rs;
    p.raw_end = re;
    p.given = given;
    p.clear = clear;
    p.typed = typed;
    p.want.lane = lane[LaneOutW-1:0];
    p.want.span_start = ss;
    p.want.span_end = se;
    p.want.opened = opened;
    p.want.overflow = overflow;
    return p;
  endfunction

  // Queue one expected result beat behind the ones already booked.
  function automatic void book_span(input span_res_t r);
    spans_due = {spans_due, r};
  endfunction

  // Offer one interval beat, with an optional leading gap; book its result on acceptance.
  // Called at a rising edge; valid is left high so back-to-back beats need no toggle.
  task automatic offer_interval(input logic signed [RawW-1:0] rs,
                                input logic signed [RawW-1:0] re,
                                input logic given, input logic clear,
                                input logic typed, input span_res_t typed_want);
    span_res_t res;
    int        gap;
    gap = (!quiet && $urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {re, rs};
    s_axis_tuser <= {clear, given};
    do @(posedge clk_i); while (!s_axis_tready);
    res = assign_lane(rs, re, given, clear);
    book_span(typed ? typed_want : res);
  endtask

  // Let every booked result drain, then the block's worst latency on top.
  task automatic drain_spans();
    s_axis_tvalid <= 1'b0;
    while (spans_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write the timeline length while the block is idle.
  task automatic set_frames(input logic [FrameW-1:0] value);
    drain_spans();
    total_frames_we_i <= 1'b1;
    total_frames_i <= value;
    frames_total = value;
    @(posedge clk_i);
    total_frames_we_i <= 1'b0;
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request so that the
  // output register fills and the block stalls its input.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LongHold - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      hold_left = $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Check each output beat against the oldest booking; watch for a stuck pipeline.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.lane = m_axis_tdata[3:0];
        got.span_start = m_axis_tdata[34:4];
        got.span_end = m_axis_tdata[65:35];
        got.opened = m_axis_tuser[0];
        got.overflow = m_axis_tuser[1];
        if (spans_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result beat with nothing booked: lane %0d start %0d end %0d",
                     $realtime, got.lane, got.span_start, got.span_end);
          end
        end else begin
          want = spans_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch exp lane %0d start %0d end %0d open %0b ovf %0b",
                       $realtime, want.lane, want.span_start, want.span_end,
                       want.opened, want.overflow);
              $display("%0t:          got lane %0d start %0d end %0d open %0b ovf %0b",
                       $realtime, got.lane, got.span_start, got.span_end,
                       got.opened, got.overflow);
            end
          end
        end
      end
      if (stall_cycles >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    plan_row_t         plan [$];
    logic [FrameW-1:0] frames_plan [NumPhases];
    int                sent;
    int                run_len;
    int                style;
    longint            cursor;
    longint            len;
    longint            endv;
    logic              given;
    bit                hold_done;

    hold_done = 1'b0;
    frames_plan[0] = 31'h7FFF_FFFF;
    frames_plan[1] = 31'd1;
    frames_plan[2] = 31'($urandom);
    frames_plan[3] = 31'd0;
    frames_plan[4] = 31'($urandom_range(1, 5000));

    // Directed table, timeline length still at its reset value of zero.
    // No end with a zero timeline: the end collapses onto the start.
    plan = {plan, mk_row(0, 0, 1'b0, 1'b1, 1'b1, 0, 0, 0, 1'b1, 1'b0)};
    // Negative start and end: both clamp to zero, lane 0 still busy at 0.
    plan = {plan, mk_row(-5, -1, 1'b1, 1'b0, 1'b1, 1, 0, 0, 1'b1, 1'b0)};
    // Most negative start, no end.
    plan = {plan, mk_row(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 1'b0, 1'b1,
                         2, 0, 0, 1'b1, 1'b0)};
    // Largest start and end reuse lane 0.
    plan = {plan, mk_row(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 1'b0, 1'b1,
                         0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, 1'b0)};
    // Explicit end below the start is lifted to the start.
    plan = {plan, mk_row(5, 3, 1'b1, 1'b0, 1'b1, 1, 5, 5, 1'b0, 1'b0)};
    plan = {plan, mk_row(6, 32'sh8000_0000, 1'b1, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0)};
    // Clear, then stack sixteen overlapping intervals to fill every lane.
    for (int unsigned i = 0; i < NumLanes; i++) begin
      plan = {plan, mk_row(10, 1000, 1'b1, i == 0, 1'b1, i, 10, 1000, 1'b1, 1'b0)};
    end
    // All lanes busy: overflow, lane 0, nothing stored.
    plan = {plan, mk_row(10, 2000, 1'b1, 1'b0, 1'b1, 0, 10, 2000, 1'b0, 1'b1)};
    plan = {plan, mk_row(1001, 0, 1'b0, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0)};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 20;
    foreach (plan[i]) begin
      offer_interval(plan[i].raw_start, plan[i].raw_end, plan[i].given, plan[i].clear,
                     plan[i].typed, plan[i].want);
    end

    // Random part: each phase runs under its own timeline length and idle rate.
    for (int ph = 0; ph < NumPhases; ph++) begin
      set_frames(frames_plan[ph]);
      quiet = (ph == NumPhases - 1);
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 10;
        default: idle_pct = 30;
      endcase
      sent = 0;
      while (sent < PhaseItems) begin
        if (ph == 0 && !hold_done && sent >= 60) begin
          hold_req = 1'b1;
          hold_done = 1'b1;
        end
        if ($urandom_range(0, 6) == 0) begin
          // Noise: any bits, any flags, no ordering
          offer_interval($urandom, $urandom, 1'($urandom_range(0, 1)),
                         $urandom_range(0, 3) == 0, 1'b0, '0);
          sent++;
        end else begin
          // Well-formed layout: cleared first, starts ascending, lengths by style
          run_len = $urandom_range(1, 40);
          style = $urandom_range(0, 2);
          if ($urandom_range(0, 9) == 0) cursor = FrameMax - $urandom_range(0, 2000);
          else cursor = longint'($urandom_range(0, 100000)) - 50;
          for (int k = 0; k < run_len && sent < PhaseItems; k++) begin
            cursor += $urandom_range(0, (style == 2) ? 3 : 40);
            if (cursor > FrameMax) cursor = FrameMax;
            case (style)
              0: len = $urandom_range(0, 20);
              1: len = $urandom_range(0, 400);
              default: len = $urandom_range(500, 1000000);
            endcase
            endv = cursor + len;
            if (endv > FrameMax) endv = FrameMax;
            given = ($urandom_range(0, 4) != 0);
            offer_interval(cursor[31:0], given ? endv[31:0] : 32'($urandom), given, k == 0,
                           1'b0, '0);
            sent++;
          end
        end
      end
    end

    drain_spans();
    if (mismatches == 0 && spans_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
